@@ rtl/dtt_pkg.sv @@
// ----------------------------------------------------------------------------
// dtt_pkg: shared definitions for the automaton transition table
// Field widths of the stream payload, command and status codes, and the
// default sizes that the top level hands to its parameters.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int CMD_W    = 2;
  localparam int LABEL_W  = 16;
  localparam int SYMBOL_W = 8;
  localparam int STATUS_W = 2;
  localparam int STATES_W = 7;

  localparam int SYMBOL_SPAN = 1 << SYMBOL_W;

  localparam int DEF_MAX_STATES   = 64;
  localparam int DEF_SYMBOL_COUNT = 256;
  localparam int DEF_LABEL_BITS   = 16;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_SRC   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_TRANS = 2'd3;

endpackage

@@ rtl/dtt_ram.sv @@
// ----------------------------------------------------------------------------
// dtt_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/dtt_label_cam.sv @@
// ----------------------------------------------------------------------------
// dtt_label_cam: label store with parallel compare
// Holds one label per allocated slot and matches two keys against all of
// them at once. Labels are unique, so the matching slot is OR-encoded.
// ----------------------------------------------------------------------------
module dtt_label_cam #(
  parameter int MAX_STATES = 64,
  parameter int LABEL_BITS = 16,
  localparam int SLOT_BITS = $clog2(MAX_STATES),
  localparam int CNT_BITS  = $clog2(MAX_STATES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clr,
  input  logic [LABEL_BITS-1:0] clr_label,
  input  logic [CNT_BITS-1:0]   count,
  input  logic                  wr_a_en,
  input  logic [SLOT_BITS-1:0]  wr_a_slot,
  input  logic [LABEL_BITS-1:0] wr_a_label,
  input  logic                  wr_b_en,
  input  logic [SLOT_BITS-1:0]  wr_b_slot,
  input  logic [LABEL_BITS-1:0] wr_b_label,
  input  logic [LABEL_BITS-1:0] key_a,
  input  logic [LABEL_BITS-1:0] key_b,
  output logic                  hit_a,
  output logic [SLOT_BITS-1:0]  slot_a,
  output logic                  hit_b,
  output logic [SLOT_BITS-1:0]  slot_b
);

  logic [LABEL_BITS-1:0] labels [MAX_STATES];
  logic [MAX_STATES-1:0] match_a;
  logic [MAX_STATES-1:0] match_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      labels[0] <= '0;
    end else begin
      if (clr) begin
        labels[0] <= clr_label;
      end
      if (wr_a_en) begin
        labels[wr_a_slot] <= wr_a_label;
      end
      if (wr_b_en) begin
        labels[wr_b_slot] <= wr_b_label;
      end
    end
  end

  // Only slots below the fill count take part in the compare.
  always_comb begin
    slot_a = '0;
    slot_b = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      match_a[i] = (CNT_BITS'(i) < count) && (labels[i] == key_a);
      match_b[i] = (CNT_BITS'(i) < count) && (labels[i] == key_b);
      slot_a     = slot_a | (match_a[i] ? SLOT_BITS'(i) : '0);
      slot_b     = slot_b | (match_b[i] ? SLOT_BITS'(i) : '0);
    end
    hit_a = |match_a;
    hit_b = |match_b;
  end

endmodule

@@ rtl/dfa_transition_table.sv @@
// ----------------------------------------------------------------------------
// dfa_transition_table: deterministic automaton table with free-form labels
// Maps arbitrary state labels to dense slots in order of first use and keeps
// a transition memory indexed by slot and symbol.
//
//   Channel | Direction | Beat content
//   --------+-----------+-------------------------------------------------
//   s_*     | in        | one command: add, mark final, lookup or clear
//   m_*     | out       | one result beat for every command beat
//   cfg_*   | in        | initial label, used at the next clear
//
// Add, mark final, a lookup of an unknown label and clear register their
// result from the resolve step; a successful lookup first passes through the
// transition memory read and then the label memory read. An add that
// allocates two new labels writes the second label into the label memory
// in an extra step. Clear, and reset, start a clearing pass over all
// MAX_STATES * 2^ceil(log2(SYMBOL_COUNT)) entries of the transition memory
// (16384 with the defaults), during which s_tready is low; configuration
// beats are taken at all times. A result that is not taken holds the block
// in its final step, while the finished beat waits in the output register.
// ----------------------------------------------------------------------------
module dfa_transition_table
  import dtt_pkg::*;
#(
  parameter int MAX_STATES   = DEF_MAX_STATES,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
  parameter int LABEL_BITS   = DEF_LABEL_BITS
) (
  input  logic                clk,
  input  logic                rst,
  // Command channel.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,  // from_label, to_label, symbol
  input  logic [CMD_W-1:0]    s_tuser,  // cmd
  // Result channel.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,  // next_label, has_transition,
                                        // source_final, target_final,
                                        // states_used, zero fill
  output logic [STATUS_W-1:0] m_tuser,  // status
  // Configuration channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LABEL_W-1:0]  cfg_data  // initial_label
);

  localparam int SLOT_BITS = $clog2(MAX_STATES);
  localparam int CNT_BITS  = $clog2(MAX_STATES + 1);
  localparam int SYM_BITS  = $clog2(SYMBOL_COUNT);
  localparam int TAB_AW    = SLOT_BITS + SYM_BITS;
  localparam int TAB_DEPTH = MAX_STATES * (1 << SYM_BITS);
  localparam int ENTRY_W   = SLOT_BITS + 1;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_WR2   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_LBL   = 3'd5;

  // Symbols wrap modulo the symbol count through a small constant table.
  typedef logic [SYM_BITS-1:0] sym_tab_t [SYMBOL_SPAN];

  function automatic sym_tab_t build_sym_tab();
    sym_tab_t t;
    for (int i = 0; i < SYMBOL_SPAN; i++) begin
      t[i] = SYM_BITS'(i % SYMBOL_COUNT);
    end
    return t;
  endfunction

  localparam sym_tab_t SYM_TAB = build_sym_tab();

  // Control and command registers.
  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CMD_W-1:0]      cmd;
  logic [LABEL_BITS-1:0] from_label;
  logic [LABEL_BITS-1:0] to_label;
  logic [SYM_BITS-1:0]   sym;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic [MAX_STATES-1:0] fin;
  logic [LABEL_W-1:0]    init_label;
  logic [LABEL_BITS-1:0] base_label;
  logic [TAB_AW-1:0]     sweep_cnt;
  logic                  entry_valid;
  logic [SLOT_BITS-1:0]  entry_slot;
  logic [SLOT_BITS-1:0]  wr2_slot;

  // Output register.
  logic                  out_free;
  logic [STATUS_W-1:0]   res_status;
  logic [LABEL_W-1:0]    res_next;
  logic                  res_has;
  logic                  res_sfin;
  logic                  res_tfin;
  logic [STATES_W-1:0]   res_used;

  // Label compare results.
  logic                  hit_a;
  logic [SLOT_BITS-1:0]  slot_a;
  logic                  hit_b;
  logic [SLOT_BITS-1:0]  slot_b;

  // Step decisions.
  logic                  load;
  logic [STATUS_W-1:0]   r_status;
  logic [LABEL_W-1:0]    r_next;
  logic                  r_has;
  logic                  r_sfin;
  logic                  r_tfin;
  logic [CNT_BITS-1:0]   r_used;
  logic                  cam_wr_a;
  logic                  cam_wr_b;
  logic                  do_mark;
  logic                  do_clear;
  logic [SLOT_BITS-1:0]  mark_slot;

  logic [1:0]            need;
  logic [CNT_BITS:0]     need_sum;
  logic                  full;
  logic                  same_label;
  logic [SLOT_BITS-1:0]  slot_new_a;
  logic [SLOT_BITS-1:0]  slot_new_b;
  logic [SLOT_BITS-1:0]  src_slot;
  logic [SLOT_BITS-1:0]  dst_slot;

  // Memory ports.
  logic                  tab_we;
  logic [TAB_AW-1:0]     tab_wa;
  logic [ENTRY_W-1:0]    tab_wd;
  logic [TAB_AW-1:0]     tab_ra;
  logic [ENTRY_W-1:0]    tab_rd;
  logic                  lbl_we;
  logic [SLOT_BITS-1:0]  lbl_wa;
  logic [LABEL_BITS-1:0] lbl_wd;
  logic [SLOT_BITS-1:0]  lbl_ra;
  logic [LABEL_BITS-1:0] lbl_rd;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign m_tuser = res_status;
  assign m_tdata = {6'd0, res_used, res_tfin, res_sfin, res_has, res_next};

  dtt_label_cam #(
    .MAX_STATES (MAX_STATES),
    .LABEL_BITS (LABEL_BITS)
  ) u_cam (
    .clk        (clk),
    .rst        (rst),
    .clr        (do_clear),
    .clr_label  (LABEL_BITS'(init_label)),
    .count      (count),
    .wr_a_en    (cam_wr_a),
    .wr_a_slot  (slot_new_a),
    .wr_a_label (from_label),
    .wr_b_en    (cam_wr_b),
    .wr_b_slot  (slot_new_b),
    .wr_b_label (to_label),
    .key_a      (from_label),
    .key_b      (to_label),
    .hit_a      (hit_a),
    .slot_a     (slot_a),
    .hit_b      (hit_b),
    .slot_b     (slot_b)
  );

  // Transition memory: one entry per (slot, symbol), a valid bit over the
  // target slot.
  dtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_wa),
    .wr_data (tab_wd),
    .rd_addr (tab_ra),
    .rd_data (tab_rd)
  );

  // Copy of the slot labels, read by slot to name a lookup's target.
  dtt_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (MAX_STATES)
  ) u_lbl_ram (
    .clk     (clk),
    .wr_en   (lbl_we),
    .wr_addr (lbl_wa),
    .wr_data (lbl_wd),
    .rd_addr (lbl_ra),
    .rd_data (lbl_rd)
  );

  // Slot allocation. New slots are taken from the fill count, the source
  // label first; an add whose two labels are equal and new uses one slot.
  always_comb begin
    same_label = (to_label == from_label);
    slot_new_a = count[SLOT_BITS-1:0];
    slot_new_b = hit_a ? count[SLOT_BITS-1:0] : SLOT_BITS'(count + 1'b1);
    if (cmd == CMD_ADD) begin
      need = {1'b0, !hit_a} + {1'b0, !hit_b && !same_label};
    end else begin
      need = {1'b0, !hit_a};
    end
    need_sum = {1'b0, count} + (CNT_BITS + 1)'(need);
    full     = need_sum > (CNT_BITS + 1)'(MAX_STATES);
    src_slot = hit_a ? slot_a : slot_new_a;
    if (hit_b) begin
      dst_slot = slot_b;
    end else if (same_label) begin
      dst_slot = src_slot;
    end else begin
      dst_slot = slot_new_b;
    end
  end

  // The transition read is issued while the source slot is being resolved.
  // The label read address follows the memory output in the read step and
  // then holds on the captured slot, so a stalled result stays stable.
  assign tab_ra = {slot_a, sym};
  assign lbl_ra = (state == S_READ) ? tab_rd[SLOT_BITS-1:0] : entry_slot;

  always_comb begin
    state_next = state;
    load       = 1'b0;
    r_status   = STAT_OK;
    r_next     = '0;
    r_has      = 1'b0;
    r_sfin     = 1'b0;
    r_tfin     = 1'b0;
    r_used     = count;
    cam_wr_a   = 1'b0;
    cam_wr_b   = 1'b0;
    do_mark    = 1'b0;
    do_clear   = 1'b0;
    mark_slot  = src_slot;
    count_next = count;
    tab_we     = 1'b0;
    tab_wa     = sweep_cnt;
    tab_wd     = '0;

    unique case (state)
      S_SWEEP: begin
        tab_we = 1'b1;
        if (sweep_cnt == TAB_AW'(TAB_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (cmd == CMD_LOOKUP && hit_a) begin
          state_next = S_READ;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          unique case (cmd)
            CMD_ADD: begin
              if (full) begin
                r_status = STAT_FULL;
              end else begin
                cam_wr_a   = !hit_a;
                cam_wr_b   = !hit_b && !same_label;
                count_next = need_sum[CNT_BITS-1:0];
                tab_we     = 1'b1;
                tab_wa     = {src_slot, sym};
                tab_wd     = {1'b1, dst_slot};
                if (!hit_a && !hit_b && !same_label) begin
                  state_next = S_WR2;
                end
              end
              r_used = full ? count : need_sum[CNT_BITS-1:0];
              r_sfin = hit_a && fin[slot_a];
            end
            CMD_MARK: begin
              if (full) begin
                r_status = STAT_FULL;
              end else begin
                cam_wr_a   = !hit_a;
                do_mark    = 1'b1;
                count_next = need_sum[CNT_BITS-1:0];
                r_sfin     = 1'b1;
              end
              r_used = full ? count : need_sum[CNT_BITS-1:0];
            end
            CMD_LOOKUP: begin
              r_status = STAT_NO_SRC;
            end
            CMD_CLEAR: begin
              do_clear   = 1'b1;
              count_next = CNT_BITS'(1);
              r_used     = CNT_BITS'(1);
              state_next = S_SWEEP;
            end
            default: begin
              r_status = STAT_OK;
            end
          endcase
        end
      end
      S_WR2: begin
        state_next = S_IDLE;
      end
      S_READ: begin
        state_next = S_LBL;
      end
      S_LBL: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          r_status   = entry_valid ? STAT_OK : STAT_NO_TRANS;
          r_next     = entry_valid ? LABEL_W'(lbl_rd) : '0;
          r_has      = entry_valid;
          r_sfin     = fin[slot_a];
          r_tfin     = entry_valid && fin[entry_slot];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Label memory writes: slot zero during the clearing pass, the first new
  // label in the resolve step, the second one in the extra write step.
  always_comb begin
    lbl_we = 1'b0;
    lbl_wa = '0;
    lbl_wd = base_label;
    priority if (state == S_SWEEP) begin
      lbl_we = 1'b1;
    end else if (state == S_WR2) begin
      lbl_we = 1'b1;
      lbl_wa = wr2_slot;
      lbl_wd = to_label;
    end else if (cam_wr_a) begin
      lbl_we = 1'b1;
      lbl_wa = slot_new_a;
      lbl_wd = from_label;
    end else if (cam_wr_b) begin
      lbl_we = 1'b1;
      lbl_wa = slot_new_b;
      lbl_wd = to_label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      count      <= CNT_BITS'(1);
      fin        <= '0;
      init_label <= '0;
      base_label <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;

      if (cfg_valid && cfg_ready) begin
        init_label <= cfg_data;
      end

      if (state == S_SWEEP) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end else begin
        sweep_cnt <= '0;
      end

      if (do_clear) begin
        fin        <= '0;
        base_label <= LABEL_BITS'(init_label);
      end else if (do_mark) begin
        fin[mark_slot] <= 1'b1;
      end

      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd        <= s_tuser;
      from_label <= LABEL_BITS'(s_tdata[15:0]);
      to_label   <= LABEL_BITS'(s_tdata[31:16]);
      sym        <= SYM_TAB[s_tdata[39:32]];
    end
    if (state == S_FIND) begin
      wr2_slot <= slot_new_b;
    end
    if (state == S_READ) begin
      entry_valid <= tab_rd[ENTRY_W-1];
      entry_slot  <= tab_rd[SLOT_BITS-1:0];
    end
    if (load) begin
      res_status <= r_status;
      res_next   <= r_next;
      res_has    <= r_has;
      res_sfin   <= r_sfin;
      res_tfin   <= r_tfin;
      res_used   <= STATES_W'(r_used);
    end
  end

endmodule

@@ tb/sv/dfa_transition_table_tb.sv @@
// ----------------------------------------------------------------------------
// dfa_transition_table_tb: self-checking bench for the automaton table
// A short list of hand-written commands is followed by six random phases.
// Each phase loads a new initial label and clears the table. It then runs
// adds, final marks and lookups over a label pool of its own, so that some
// phases fill the table and others walk the automaton that they build.
// Every beat is checked against a typed answer or a behavioral table copy.
// ----------------------------------------------------------------------------
module dfa_transition_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtt_pkg::*;

  localparam int MAX_ST      = DEF_MAX_STATES;
  localparam int SYM_N       = DEF_SYMBOL_COUNT;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 180;
  // The receiver stalls once for a long stretch after this many results.
  localparam int HOLD_AFTER  = 520;
  localparam int HOLD_CYCLES = 400;
  // Extra wait once the last pending result has been taken.
  localparam int SETTLE      = 16;

  // One result beat, unpacked into its fields.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LABEL_W-1:0]  next_label;
    logic                has_trans;
    logic                src_final;
    logic                tgt_final;
    logic [STATES_W-1:0] used;
  } answer_t;

  // One directed command. Rows with typed set carry their own answer; the
  // rest take the answer that the table copy works out.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LABEL_W-1:0]  from_lbl;
    logic [LABEL_W-1:0]  to_lbl;
    logic [SYMBOL_W-1:0] sym;
    logic                typed;
    answer_t             want;
  } row_t;

  localparam int N_DIRECTED = 22;
  // Starts right after reset, so the initial label is 0 and slot 0 holds it.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // Initial label is known but has no transitions yet.
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 8'h00, 1'b1,
      '{STAT_NO_TRANS, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd1}},
    // Unknown source, all-ones label and symbol.
    '{CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'hFF, 1'b1,
      '{STAT_NO_SRC, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd1}},
    '{CMD_ADD,    16'h0000, 16'hFFFF, 8'hFF, 1'b1,
      '{STAT_OK, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd2}},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 8'hFF, 1'b1,
      '{STAT_OK, 16'hFFFF, 1'b1, 1'b0, 1'b0, 7'd2}},
    '{CMD_MARK,   16'hFFFF, 16'h0000, 8'h00, 1'b1,
      '{STAT_OK, 16'h0000, 1'b0, 1'b1, 1'b0, 7'd2}},
    // The target is now final.
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 8'hFF, 1'b1,
      '{STAT_OK, 16'hFFFF, 1'b1, 1'b0, 1'b1, 7'd2}},
    // A self loop on a new label takes a single slot.
    '{CMD_ADD,    16'h1234, 16'h1234, 8'h00, 1'b1,
      '{STAT_OK, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd3}},
    '{CMD_LOOKUP, 16'h1234, 16'hFFFF, 8'h00, 1'b1,
      '{STAT_OK, 16'h1234, 1'b1, 1'b0, 1'b0, 7'd3}},
    // Overwrite the self loop with an edge back to the start.
    '{CMD_ADD,    16'h1234, 16'h0000, 8'h00, 1'b0, '0},
    '{CMD_LOOKUP, 16'h1234, 16'h0000, 8'h00, 1'b0, '0},
    // Marking an unknown label allocates it.
    '{CMD_MARK,   16'hA5A5, 16'hFFFF, 8'hFF, 1'b1,
      '{STAT_OK, 16'h0000, 1'b0, 1'b1, 1'b0, 7'd4}},
    // Both labels new: two slots in one beat.
    '{CMD_ADD,    16'h5A5A, 16'hC3C3, 8'hAA, 1'b0, '0},
    '{CMD_LOOKUP, 16'h5A5A, 16'h0000, 8'h55, 1'b1,
      '{STAT_NO_TRANS, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd6}},
    '{CMD_LOOKUP, 16'h5A5A, 16'h0000, 8'hAA, 1'b0, '0},
    '{CMD_ADD,    16'hFFFF, 16'h5A5A, 8'h80, 1'b0, '0},
    '{CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'h80, 1'b0, '0},
    '{CMD_MARK,   16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 8'hFF, 1'b0, '0},
    // Clear drops everything but the initial label.
    '{CMD_CLEAR,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
      '{STAT_OK, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd1}},
    '{CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'hFF, 1'b1,
      '{STAT_NO_SRC, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd1}},
    '{CMD_LOOKUP, 16'h0000, 16'h0000, 8'h80, 1'b1,
      '{STAT_NO_TRANS, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd1}},
    '{CMD_ADD,    16'h0001, 16'h8000, 8'h01, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [39:0]         s_tdata;   // from_label, to_label, symbol
  logic [CMD_W-1:0]    s_tuser;   // cmd
  logic                m_tvalid;
  logic                m_tready;
  logic [31:0]         m_tdata;   // next_label, has_transition, source_final,
                                  // target_final, states_used, zero fill
  logic [STATUS_W-1:0] m_tuser;   // status
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LABEL_W-1:0]  cfg_data;  // initial_label

  dfa_transition_table u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Behavioral copy of the table. next_slot holds the target slot plus one,
  // with zero meaning that the pair has no transition.
  logic [LABEL_W-1:0] start_label;
  logic [LABEL_W-1:0] slot_label [MAX_ST];
  bit                 slot_final [MAX_ST];
  bit [7:0]           next_slot  [MAX_ST][SYM_N];
  int unsigned        slots_used;

  answer_t answers_due [$];
  int      fault_count;
  int      results_taken;
  bit      steady_flow;

  function automatic void empty_table();
    for (int s = 0; s < MAX_ST; s++) begin
      slot_label[s] = '0;
      slot_final[s] = 1'b0;
      for (int y = 0; y < SYM_N; y++) next_slot[s][y] = '0;
    end
    slot_label[0] = start_label;
    slots_used = 1;
  endfunction

  function automatic int find_label(logic [LABEL_W-1:0] lbl);
    for (int s = 0; s < slots_used && s < MAX_ST; s++)
      if (slot_label[s] == lbl) return s;
    return -1;
  endfunction

  // New labels go to the next free slot with a fresh, empty row.
  function automatic int grab_slot(logic [LABEL_W-1:0] lbl);
    int s;
    s = slots_used;
    slot_label[s] = lbl;
    slot_final[s] = 1'b0;
    for (int y = 0; y < SYM_N; y++) next_slot[s][y] = '0;
    slots_used = s + 1;
    return s;
  endfunction

  // Applies one command to the table copy and returns the result beat that
  // it must produce.
  function automatic answer_t table_step(logic [CMD_W-1:0] cmd,
                                         logic [LABEL_W-1:0] from_lbl,
                                         logic [LABEL_W-1:0] to_lbl,
                                         logic [SYMBOL_W-1:0] sym);
    answer_t a;
    int sf, st, need;
    int unsigned e;
    a = '0;
    sf = find_label(from_lbl);
    case (cmd)
      CMD_ADD: begin
        st = find_label(to_lbl);
        need = 0;
        if (sf < 0) need++;
        if (st < 0 && to_lbl != from_lbl) need++;
        // All or nothing: a full table rejects the add without allocating.
        if (slots_used + need > MAX_ST) begin
          a.status = STAT_FULL;
        end else begin
          if (sf < 0) sf = grab_slot(from_lbl);
          if (st < 0) st = (to_lbl == from_lbl) ? sf : grab_slot(to_lbl);
          next_slot[sf][sym] = 8'(st + 1);
        end
        if (sf >= 0) a.src_final = slot_final[sf];
      end
      CMD_MARK: begin
        if (sf < 0) begin
          if (slots_used + 1 > MAX_ST) a.status = STAT_FULL;
          else sf = grab_slot(from_lbl);
        end
        if (sf >= 0) begin
          slot_final[sf] = 1'b1;
          a.src_final = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (sf < 0) begin
          a.status = STAT_NO_SRC;
        end else begin
          e = next_slot[sf][sym];
          a.src_final = slot_final[sf];
          if (e == 0 || e > slots_used) begin
            a.status = STAT_NO_TRANS;
          end else begin
            a.next_label = slot_label[e-1];
            a.has_trans  = 1'b1;
            a.tgt_final  = slot_final[e-1];
          end
        end
      end
      CMD_CLEAR: empty_table();
      default: ;
    endcase
    a.used = STATES_W'(slots_used);
    return a;
  endfunction

  function automatic void note_fault(string msg);
    if (fault_count < 10) $display("%0t ns: %s", $time, msg);
    fault_count++;
  endfunction

  // Appends an answer behind the ones already pending.
  function automatic void queue_answer(answer_t a);
    answers_due = {answers_due, a};
  endfunction

  // Offers one command beat from the falling edge on, with random gaps
  // before it, and returns once it is taken. The table copy is updated at
  // the accepting edge. Only one assignment to s_tvalid happens per edge.
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic [LABEL_W-1:0] from_lbl,
                               input logic [LABEL_W-1:0] to_lbl,
                               input logic [SYMBOL_W-1:0] sym,
                               output answer_t predicted);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sym, to_lbl, from_lbl};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = table_step(cmd, from_lbl, to_lbl, sym);
  endtask

  // Writes the initial label once the block has drained. Called right after
  // a command beat was accepted, so lowering s_tvalid here is the only
  // assignment to it at this edge.
  task automatic load_start_label(input logic [LABEL_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    start_label = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, except in the steady phase, plus one long
  // hold so that the block backs up and stops taking commands.
  initial begin : result_pacing
    bit held_off;
    held_off = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= steady_flow || ($urandom_range(99) >= 20);
      end
    end
  end

  // Each result beat is matched against the oldest pending answer.
  always @(posedge clk) begin : check_results
    answer_t want;
    answer_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_taken++;
      got.status     = m_tuser;
      got.next_label = m_tdata[15:0];
      got.has_trans  = m_tdata[16];
      got.src_final  = m_tdata[17];
      got.tgt_final  = m_tdata[18];
      got.used       = m_tdata[25:19];
      if (answers_due.size() == 0) begin
        note_fault($sformatf("result beat with nothing pending: status %0d next %h",
                             got.status, got.next_label));
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status || got.next_label !== want.next_label ||
            got.has_trans !== want.has_trans || got.src_final !== want.src_final ||
            got.tgt_final !== want.tgt_final || got.used !== want.used)
          note_fault($sformatf({"mismatch: expected st %0d nx %h ht %b sf %b tf %b ",
                                "used %0d; got st %0d nx %h ht %b sf %b tf %b used %0d"},
                               want.status, want.next_label, want.has_trans,
                               want.src_final, want.tgt_final, want.used,
                               got.status, got.next_label, got.has_trans,
                               got.src_final, got.tgt_final, got.used));
      end
    end
  end

  initial begin : stimulus
    answer_t            ans;
    logic [LABEL_W-1:0] pool [$];
    logic [SYMBOL_W-1:0] syms [6];
    logic [LABEL_W-1:0] new_start;
    logic [LABEL_W-1:0] walk_label;
    logic [LABEL_W-1:0] from_lbl;
    logic [LABEL_W-1:0] to_lbl;
    logic [SYMBOL_W-1:0] sym;
    logic [CMD_W-1:0]   cmd;
    bit                 have_walk;
    int                 pool_size;
    int                 roll;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_ADD;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    steady_flow = 1'b0;
    fault_count = 0;
    results_taken = 0;
    start_label = '0;
    empty_table();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The first command waits out the clearing pass that follows reset.

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_command(DIRECTED[i].cmd, DIRECTED[i].from_lbl, DIRECTED[i].to_lbl,
                    DIRECTED[i].sym, ans);
      queue_answer(DIRECTED[i].typed ? DIRECTED[i].want : ans);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // Initial labels at both extremes, two mixed patterns and random ones.
      case (ph)
        0:       new_start = 16'hFFFF;
        1:       new_start = 16'h0000;
        2:       new_start = 16'h8001;
        4:       new_start = 16'h7FFE;
        default: new_start = 16'($urandom);
      endcase
      // Small pools revisit labels and build rich graphs; large ones run
      // the table into its full condition.
      case (ph)
        0:       pool_size = 12;
        1:       pool_size = 90;
        2:       pool_size = 30;
        3:       pool_size = 100;
        4:       pool_size = 8;
        default: pool_size = 70;
      endcase

      // The drain before the write also serves as the sender pause.
      load_start_label(new_start);
      // Phase 2 runs without random gaps on either side; the long hold of the result side still falls within it.
      steady_flow = (ph == 2);

      pool.delete();
      pool = {pool, new_start};
      repeat (pool_size - 1) pool = {pool, 16'($urandom)};
      syms[0] = ph[0] ? 8'h00 : 8'hFF;
      for (int k = 1; k < 6; k++) syms[k] = 8'($urandom);

      // The new initial label only takes hold at the next clear.
      issue_command(CMD_LOOKUP, new_start, 16'($urandom), syms[0], ans);
      queue_answer(ans);
      issue_command(CMD_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), ans);
      queue_answer(ans);
      have_walk = 1'b0;

      repeat (PHASE_ITEMS) begin
        from_lbl = ($urandom_range(9) == 0) ? 16'($urandom)
                                            : pool[$urandom_range(pool_size - 1)];
        to_lbl   = ($urandom_range(9) == 0) ? 16'($urandom)
                                            : pool[$urandom_range(pool_size - 1)];
        sym      = ($urandom_range(99) < 15) ? 8'($urandom) : syms[$urandom_range(5)];
        roll = $urandom_range(99);
        if (roll < 40)      cmd = CMD_ADD;
        else if (roll < 55) cmd = CMD_MARK;
        else                cmd = CMD_LOOKUP;
        // Lookups often follow the last edge found, walking the automaton.
        if (cmd == CMD_LOOKUP && have_walk && $urandom_range(99) < 40)
          from_lbl = walk_label;
        issue_command(cmd, from_lbl, to_lbl, sym, ans);
        queue_answer(ans);
        if (cmd == CMD_LOOKUP && ans.has_trans) begin
          walk_label = ans.next_label;
          have_walk  = 1'b1;
        end
      end
    end

    steady_flow = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fault_count == 0 && answers_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Several clearing passes over the whole transition memory dominate the run;
  // this bound is many times the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dtt_pkg.sv
rtl/dtt_ram.sv
rtl/dtt_label_cam.sv
rtl/dfa_transition_table.sv
tb/sv/dfa_transition_table_tb.sv
